FILE: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and codes for the byte ring buffer: operation kinds, result
// status codes, payload structs and the controller/datapath handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  // operation kinds
  localparam logic [2:0] KIND_PUSH     = 3'd0;
  localparam logic [2:0] KIND_TRY_PUSH = 3'd1;
  localparam logic [2:0] KIND_POP      = 3'd2;
  localparam logic [2:0] KIND_PEEK     = 3'd3;
  localparam logic [2:0] KIND_CLEAR    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_BEYOND = 2'd3;

  // capacity register after reset
  localparam logic [8:0] CAP_RESET = 9'd256;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] peek_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [8:0] occupancy;
    logic       is_full;
    logic       is_empty;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic finish_read;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic need_read;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte ring buffer with overwrite push, try push, pop, peek and clear.
//
// Input channel (in_valid / in_stall / in_item): one beat is one operation.
// Result channel (out_valid / out_stall / out_item): exactly one result beat
// per operation, in order, carrying the byte read, a status code and the
// occupancy, full and empty state after the operation.
// Push, try push, clear, unknown kinds and failed pop or peek show their
// result in the cycle after acceptance; a good pop or peek passes through
// the registered read port of the store and then the result register.
// Writes go at one beat a cycle while the result slot is free; a read
// holds off the next beat until its byte lands in the result register.
// A result register decouples the sides: a new beat is taken while the
// previous result is being taken downstream. When the receiver stalls with
// a result waiting, in_stall rises and the result holds steady.
// Reset empties the buffer and sets capacity to 256 slots (clamped to
// DEPTH). A cfg_wr_en write sets the capacity and empties the buffer too;
// write it only with no operation in flight. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer #(
  parameter int DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // operation beats
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire brb_pkg::in_item_t  in_item,
  // result beats
  output logic                    out_valid,
  input  wire logic               out_stall,
  output brb_pkg::out_item_t      out_item,
  // capacity register
  input  wire logic               cfg_wr_en,
  input  wire logic [8:0]         cfg_wr_data
);

  brb_pkg::dp_cmd_t  cmd;
  brb_pkg::dp_stat_t stat;

  // sequencer: decides when to take a beat and when the read byte lands
  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // indices, flags, store and result register
  brb_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Ring indices, full flag, capacity register, byte store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_datapath #(
  parameter int DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire brb_pkg::in_item_t  in_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [8:0]         cfg_wr_data,
  input  wire brb_pkg::dp_cmd_t   cmd,
  output brb_pkg::dp_stat_t       stat,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output brb_pkg::out_item_t      out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  logic [8:0]          cap_r;
  logic [AW-1:0]       wr_r, wr_nxt;
  logic [AW-1:0]       rd_r, rd_nxt;
  logic                full_r, full_nxt;
  logic                out_valid_r, out_valid_nxt;
  brb_pkg::out_item_t  out_r, out_nxt;

  logic [CW-1:0]       slots;
  logic [CW-1:0]       held_now;
  logic [CW-1:0]       held_after;
  logic [PW-1:0]       peek_pos;
  logic [1:0]          status;
  logic                store_en;
  logic                need_read;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          ram_q;
  logic                taken;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] v,
                                              input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(v) + CW'(1);
    return (n >= c) ? '0 : AW'(n);
  endfunction

  function automatic logic [CW-1:0] held(input logic [AW-1:0] w,
                                         input logic [AW-1:0] r,
                                         input logic          f,
                                         input logic [CW-1:0] c);
    logic [CW-1:0] n;
    if (f) begin
      n = c;
    end else if (w >= r) begin
      n = CW'(w) - CW'(r);
    end else begin
      n = c + CW'(w) - CW'(r);
    end
    return n;
  endfunction

  // clamp capacity: zero acts as one, above the store acts as the store
  always_comb begin
    if (cap_r == '0) begin
      slots = CW'(1);
    end else if ({23'd0, cap_r} > 32'(DEPTH)) begin
      slots = CW'(DEPTH);
    end else begin
      slots = CW'(cap_r);
    end
  end

  assign held_now = held(wr_r, rd_r, full_r, slots);

  // peek address: offset below occupancy, so one wrap at most
  always_comb begin
    peek_pos = PW'(rd_r) + PW'(in_item.peek_offset);
    if (peek_pos >= PW'(slots)) begin
      peek_pos = peek_pos - PW'(slots);
    end
  end

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    full_nxt  = full_r;
    status    = brb_pkg::STAT_OK;
    store_en  = 1'b0;
    need_read = 1'b0;
    rd_addr   = rd_r;
    case (in_item.kind)
      brb_pkg::KIND_PUSH, brb_pkg::KIND_TRY_PUSH: begin
        if (in_item.kind == brb_pkg::KIND_TRY_PUSH && full_r) begin
          status = brb_pkg::STAT_FULL;
        end else begin
          store_en = 1'b1;
          if (full_r) begin
            rd_nxt = next_slot(rd_r, slots);
          end
          wr_nxt   = next_slot(wr_r, slots);
          full_nxt = (wr_nxt == rd_nxt);
        end
      end
      brb_pkg::KIND_POP: begin
        if (held_now == '0) begin
          status = brb_pkg::STAT_EMPTY;
        end else begin
          need_read = 1'b1;
          rd_nxt    = next_slot(rd_r, slots);
          full_nxt  = 1'b0;
        end
      end
      brb_pkg::KIND_PEEK: begin
        if (held_now == '0) begin
          status = brb_pkg::STAT_EMPTY;
        end else if (PW'(in_item.peek_offset) >= PW'(held_now)) begin
          status = brb_pkg::STAT_BEYOND;
        end else begin
          need_read = 1'b1;
          rd_addr   = AW'(peek_pos);
        end
      end
      brb_pkg::KIND_CLEAR: begin
        wr_nxt   = '0;
        rd_nxt   = '0;
        full_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign held_after = held(wr_nxt, rd_nxt, full_nxt, slots);
  assign taken      = out_valid_r && !out_stall;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !taken;
    if (cmd.accept) begin
      out_nxt.read_byte = '0;
      out_nxt.status    = status;
      out_nxt.occupancy = 9'(held_after);
      out_nxt.is_full   = full_nxt;
      out_nxt.is_empty  = (held_after == '0);
      out_valid_nxt     = !need_read;
    end
    if (cmd.finish_read) begin
      out_nxt.read_byte = ram_q;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= brb_pkg::CAP_RESET;
      wr_r        <= '0;
      rd_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r  <= cfg_wr_data;
        wr_r   <= '0;
        rd_r   <= '0;
        full_r <= 1'b0;
      end else if (cmd.accept) begin
        wr_r   <= wr_nxt;
        rd_r   <= rd_nxt;
        full_r <= full_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && store_en),
    .wr_addr (wr_r),
    .wr_data (in_item.data_byte),
    .rd_en   (cmd.accept && need_read),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign stat.slot_free = !out_valid_r || !out_stall;
  assign stat.need_read = need_read;
  assign out_valid      = out_valid_r;
  assign out_item       = out_r;

endmodule

`default_nettype wire

FILE: rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: takes a beat when the result slot is free, waits in ST_READ for
// the store read on pop and peek.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire brb_pkg::dp_stat_t stat,
  output brb_pkg::dp_cmd_t       cmd
);

  brb_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brb_pkg::ST_IDLE: begin
        if (cmd.accept && stat.need_read) begin
          state_nxt = brb_pkg::ST_READ;
        end
      end
      brb_pkg::ST_READ: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = brb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    cmd.accept      = 1'b0;
    cmd.finish_read = 1'b0;
    case (state_r)
      brb_pkg::ST_IDLE: begin
        in_stall   = !stat.slot_free;
        cmd.accept = in_valid && stat.slot_free;
      end
      brb_pkg::ST_READ: begin
        cmd.finish_read = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks on the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire brb_pkg::out_item_t out_item
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed under stall");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty flag tracks occupancy
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.is_empty == (out_item.occupancy == 9'd0))
    else $error("empty flag disagrees with occupancy");

  // failed operations carry no byte
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != brb_pkg::STAT_OK |-> out_item.read_byte == 8'd0)
    else $error("failed operation returned a byte");

  // hold off new beats while a result waits under stall
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_valid && out_stall |-> in_stall)
    else $error("input beat taken with a result held");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_item    (out_item)
);

`default_nettype wire
